/* rtl/core/hevc_short_term_rps_parser_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the short-term RPS parser modules.
// Both expect a clock named aclk and an active-low reset named aresetn.
// ----------------------------------------------------------------------------
`ifndef HEVC_SHORT_TERM_RPS_PARSER_MACROS_SVH
`define HEVC_SHORT_TERM_RPS_PARSER_MACROS_SVH

// Same-cycle implication
`define HSRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hsrp_pkg.sv */
// ----------------------------------------------------------------------------
// hsrp_pkg
// Types, codes and helpers of the short-term reference picture set parser.
// ----------------------------------------------------------------------------
package hsrp_pkg;

    localparam int MAX_SETS_DEF    = 64;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CNT_W           = 5;
    localparam int DELTA_W         = 16;
    localparam logic [4:0] MAX_REFS_RST = 5'd16;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_BAD_IDX  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // prediction walk segments
    localparam logic [2:0] SEG_POS_NEG  = 3'd0;
    localparam logic [2:0] SEG_SELF_NEG = 3'd1;
    localparam logic [2:0] SEG_NEG_NEG  = 3'd2;
    localparam logic [2:0] SEG_NEG_POS  = 3'd3;
    localparam logic [2:0] SEG_SELF_POS = 3'd4;
    localparam logic [2:0] SEG_POS_POS  = 3'd5;

    typedef struct packed {
        logic       first;
        logic [6:0] set_index;
        logic       in_slice;
        logic       bit_req;
    } rps_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               entry_valid;
        logic               list_sel;
        logic [3:0]         entry_index;
        logic signed [15:0] delta_poc;
        logic               used_by_curr;
        logic [4:0]         num_negative;
        logic [4:0]         num_positive;
        logic [4:0]         num_total_curr;
        logic               last;
    } rps_out_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PRED, PH_DIDX, PH_SIGN, PH_ABS, PH_USED, PH_USE, PH_NNEG,
        PH_NPOS, PH_NEGD, PH_NEGU, PH_POSD, PH_POSU, PH_BLD_A, PH_BLD_D, PH_BLD_END
    } phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    // finished set or failure handed from front to back
    typedef struct packed {
        logic             is_set;
        logic [1:0]       status;
        logic [CNT_W-1:0] num_neg;
        logic [CNT_W-1:0] num_pos;
        logic [CNT_W-1:0] num_used;
        logic [6:0]       slot;
    } job_t;

    // back status seen by the front
    typedef struct packed {
        logic busy;
        logic cnt_hit;
    } back_stat_t;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
        if (x > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -19'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

endpackage

/* rtl/core/hsrp_ram.sv */
// ----------------------------------------------------------------------------
// hsrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then read into the registered read data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/hsrp_front.sv */
// ----------------------------------------------------------------------------
// hsrp_front
// Bit parser: Exp-Golomb decode, explicit set capture and predicted set walk.
// ----------------------------------------------------------------------------
module hsrp_front
    import hsrp_pkg::*;
#(
    parameter int MAX_SETS    = MAX_SETS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int SW  = $clog2(MAX_SETS + 1),
    localparam int AW  = $clog2((MAX_SETS + 1) * MAX_ENTRIES),
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int FW  = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rps_in_t              s_data,
    input  logic                 cfg_wr_en,
    input  logic [4:0]           cfg_wr_data,
    input  back_stat_t           back_stat,
    output logic [SW-1:0]        cnt_rd_slot,
    input  logic [2*CNT_W-1:0]   cnt_rd_data,
    output logic [AW-1:0]        dl_rd_addr,
    input  logic [DELTA_W-1:0]   dl_rd_data,
    input  logic [EIW-1:0]       buf_rd_idx,
    output logic [DELTA_W:0]     buf_rd_data,
    output logic                 job_push,
    output job_t                 job
);

    phase_t                  phase_reg, phase_next;
    logic [4:0]              zc_reg, zc_next;
    logic [16:0]             acc_reg, acc_next;
    logic [MAX_ENTRIES:0]    used_reg, used_next;
    logic [MAX_ENTRIES:0]    apply_reg, apply_next;
    logic signed [17:0]      sd_reg, sd_next;
    logic signed [15:0]      run_reg, run_next;
    logic [CNT_W-1:0]        ic_reg, ic_next;
    logic [SW-1:0]           cur_reg, cur_next;
    logic [SW-1:0]           src_reg, src_next;
    logic                    slice_reg, slice_next;
    logic [15:0]             cneg_reg, cneg_next;
    logic [CNT_W-1:0]        cpos_reg, cpos_next;
    logic [4:0]              maxrefs_reg;
    logic [CNT_W-1:0]        wtot_reg, wtot_next;
    logic [CNT_W-1:0]        wn_reg, wn_next;
    logic [CNT_W-1:0]        wu_reg, wu_next;
    logic                    ovf_reg, ovf_next;
    logic [2:0]              seg_reg, seg_next;
    logic [CNT_W-1:0]        p_reg, p_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic                    push_reg, push_next;
    job_t                    job_reg, job_next;
    logic [DELTA_W:0]        wbuf_reg [MAX_ENTRIES];
    logic                    wbuf_we;
    logic [DELTA_W:0]        wbuf_wdata;
    logic                    accept;
    logic [CNT_W-1:0]        src_nn, src_np, src_nd;

    // start position and length of one walk segment
    function automatic logic [2*CNT_W-1:0] seg_init(input logic [2:0] s,
                                                    input logic [CNT_W-1:0] nn,
                                                    input logic [CNT_W-1:0] np);
        logic [CNT_W-1:0] nd;
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] r;
        nd = nn + np;
        case (s)
            SEG_POS_NEG:  begin p = nd - 1'b1; r = np;   end
            SEG_SELF_NEG: begin p = nd;        r = 5'd1; end
            SEG_NEG_NEG:  begin p = '0;        r = nn;   end
            SEG_NEG_POS:  begin p = nn - 1'b1; r = nn;   end
            SEG_SELF_POS: begin p = nd;        r = 5'd1; end
            default:      begin p = nn;        r = np;   end
        endcase
        return {p, r};
    endfunction

    // source set counts; unwritten slots read as empty
    assign src_nn = back_stat.cnt_hit ? cnt_rd_data[2*CNT_W-1:CNT_W] : '0;
    assign src_np = back_stat.cnt_hit ? cnt_rd_data[CNT_W-1:0] : '0;
    assign src_nd = src_nn + src_np;
    assign accept = s_valid && s_ready;

    // next state and datapath
    always_comb begin
        phase_t             ph;
        logic               bt;
        logic               g_done;
        logic               g_err;
        logic [15:0]        g_val;
        logic [16:0]        vp1;
        logic [16:0]        acc_sh;
        logic [4:0]         zc_g;
        logic [16:0]        acc_g;
        logic [CNT_W-1:0]   ic1;
        logic [CNT_W-1:0]   lim;
        logic [CNT_W-1:0]   cnt;
        logic signed [18:0] d_w;
        logic               neg_seg;
        logic               cond;
        logic               adv;
        logic               do_fail;
        logic               do_fin;
        logic [1:0]         fail_st;
        logic [2*CNT_W-1:0] si;

        phase_next = phase_reg;
        zc_next    = zc_reg;
        acc_next   = acc_reg;
        used_next  = used_reg;
        apply_next = apply_reg;
        sd_next    = sd_reg;
        run_next   = run_reg;
        ic_next    = ic_reg;
        cur_next   = cur_reg;
        src_next   = src_reg;
        slice_next = slice_reg;
        cneg_next  = cneg_reg;
        cpos_next  = cpos_reg;
        wtot_next  = wtot_reg;
        wn_next    = wn_reg;
        wu_next    = wu_reg;
        ovf_next   = ovf_reg;
        seg_next   = seg_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        push_next  = 1'b0;
        job_next   = job_reg;
        wbuf_we    = 1'b0;
        wbuf_wdata = '0;
        do_fail    = 1'b0;
        do_fin     = 1'b0;
        fail_st    = ST_OK;
        adv        = 1'b0;
        bt         = s_data.bit_req;
        ph         = phase_reg;
        d_w        = '0;
        neg_seg    = 1'b0;
        cond       = 1'b0;
        si         = '0;

        // start a new set: sample index and slice mode, clear work state
        if (accept && s_data.first) begin
            if (int'(s_data.set_index) > MAX_SETS) begin
                do_fail = 1'b1;
                fail_st = ST_BAD_IDX;
                ph      = PH_IDLE;
            end else begin
                cur_next   = SW'(s_data.set_index);
                slice_next = s_data.in_slice;
                zc_next    = '0;
                acc_next   = '0;
                used_next  = '0;
                apply_next = '0;
                sd_next    = '0;
                run_next   = '0;
                ic_next    = '0;
                src_next   = '0;
                cneg_next  = '0;
                cpos_next  = '0;
                wtot_next  = '0;
                wn_next    = '0;
                wu_next    = '0;
                ph = (s_data.set_index != '0) ? PH_PRED : PH_NNEG;
            end
        end

        // Exp-Golomb step on the current bit
        g_done = 1'b0;
        g_err  = 1'b0;
        g_val  = '0;
        zc_g   = zc_next;
        acc_g  = acc_next;
        acc_sh = {acc_next[15:0], bt};
        if (acc_next == '0) begin
            if (!bt) begin
                if (zc_next == 5'd16) begin
                    g_err = 1'b1;
                    zc_g  = '0;
                end else begin
                    zc_g = zc_next + 1'b1;
                end
            end else if (zc_next == '0) begin
                g_done = 1'b1;
            end else begin
                acc_g = 17'd1;
            end
        end else begin
            zc_g = zc_next - 1'b1;
            if (zc_g == '0) begin
                acc_g = '0;
                if (acc_sh > 17'd65536) begin
                    g_err = 1'b1;
                end else begin
                    g_done = 1'b1;
                    g_val  = 16'(acc_sh - 17'd1);
                end
            end else begin
                acc_g = acc_sh;
            end
        end
        vp1 = {1'b0, g_val} + 17'd1;
        lim = (maxrefs_reg > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : maxrefs_reg;
        ic1 = ic_next + 1'b1;
        cnt = (ph == PH_NEGU) ? cneg_next[CNT_W-1:0] : cpos_next;

        if (accept && !do_fail) begin
            case (ph)
                PH_PRED: begin
                    if (!bt) begin
                        phase_next = PH_NNEG;
                    end else if (slice_next) begin
                        phase_next = PH_DIDX;
                    end else begin
                        src_next   = cur_next - 1'b1;
                        phase_next = PH_SIGN;
                    end
                end
                PH_DIDX: begin
                    zc_next  = zc_g;
                    acc_next = acc_g;
                    if (g_err) begin
                        do_fail = 1'b1;
                        fail_st = ST_RANGE;
                    end else if (g_done) begin
                        if (vp1 > 17'(cur_next)) begin
                            do_fail = 1'b1;
                            fail_st = ST_BAD_IDX;
                        end else begin
                            src_next   = SW'(17'(cur_next) - vp1);
                            phase_next = PH_SIGN;
                        end
                    end else begin
                        phase_next = PH_DIDX;
                    end
                end
                PH_SIGN: begin
                    sd_next    = bt ? -18'sd1 : 18'sd1;
                    phase_next = PH_ABS;
                end
                PH_ABS: begin
                    zc_next  = zc_g;
                    acc_next = acc_g;
                    if (g_err) begin
                        do_fail = 1'b1;
                        fail_st = ST_RANGE;
                    end else if (g_done) begin
                        sd_next    = sd_next[17] ? -$signed({1'b0, vp1}) : $signed({1'b0, vp1});
                        ic_next    = '0;
                        phase_next = PH_USED;
                    end
                end
                PH_USED: begin
                    if (!bt) begin
                        phase_next = PH_USE;
                    end else begin
                        used_next[ic_next[FW-1:0]]  = 1'b1;
                        apply_next[ic_next[FW-1:0]] = 1'b1;
                        adv = 1'b1;
                    end
                end
                PH_USE: begin
                    if (bt) begin
                        apply_next[ic_next[FW-1:0]] = 1'b1;
                    end
                    adv = 1'b1;
                end
                PH_NNEG: begin
                    zc_next    = zc_g;
                    acc_next   = acc_g;
                    phase_next = PH_NNEG;
                    if (g_err) begin
                        do_fail = 1'b1;
                        fail_st = ST_RANGE;
                    end else if (g_done) begin
                        cneg_next  = g_val;
                        phase_next = PH_NPOS;
                    end
                end
                PH_NPOS: begin
                    zc_next  = zc_g;
                    acc_next = acc_g;
                    if (g_err) begin
                        do_fail = 1'b1;
                        fail_st = ST_RANGE;
                    end else if (g_done) begin
                        if (17'(cneg_next) + 17'(g_val) > 17'(lim)) begin
                            do_fail = 1'b1;
                            fail_st = ST_TOO_MANY;
                        end else begin
                            cpos_next = CNT_W'(g_val);
                            ic_next   = '0;
                            run_next  = '0;
                            if (cneg_next != '0) begin
                                phase_next = PH_NEGD;
                            end else if (g_val != '0) begin
                                phase_next = PH_POSD;
                            end else begin
                                do_fin = 1'b1;
                            end
                        end
                    end
                end
                PH_NEGD, PH_POSD: begin
                    zc_next  = zc_g;
                    acc_next = acc_g;
                    if (g_err) begin
                        do_fail = 1'b1;
                        fail_st = ST_RANGE;
                    end else if (g_done) begin
                        if (ph == PH_NEGD) begin
                            run_next   = sat16(19'(run_next) - 19'(vp1));
                            phase_next = PH_NEGU;
                        end else begin
                            run_next   = sat16(19'(run_next) + 19'(vp1));
                            phase_next = PH_POSU;
                        end
                    end
                end
                PH_NEGU, PH_POSU: begin
                    // append the entry in output order
                    wbuf_we    = 1'b1;
                    wbuf_wdata = {bt, run_next};
                    wtot_next  = wtot_next + 1'b1;
                    wu_next    = wu_next + CNT_W'(bt);
                    if (ph == PH_NEGU) begin
                        wn_next = wn_next + 1'b1;
                    end
                    ic_next = ic1;
                    if (ic1 < cnt) begin
                        phase_next = (ph == PH_NEGU) ? PH_NEGD : PH_POSD;
                    end else if (ph == PH_NEGU && cpos_next != '0) begin
                        ic_next    = '0;
                        run_next   = '0;
                        phase_next = PH_POSD;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // advance the flag pointer; past the last flag, start the walk
        if (adv) begin
            ic_next    = ic1;
            phase_next = PH_USED;
            if (ic1 > src_nd) begin
                si         = seg_init(SEG_POS_NEG, src_nn, src_np);
                seg_next   = SEG_POS_NEG;
                p_next     = si[2*CNT_W-1:CNT_W];
                rem_next   = si[CNT_W-1:0];
                wtot_next  = '0;
                wn_next    = '0;
                wu_next    = '0;
                ovf_next   = 1'b0;
                phase_next = PH_BLD_A;
            end
        end

        // predicted set walk over the source entries
        case (phase_reg)
            PH_BLD_A: begin
                if (rem_reg == '0) begin
                    if (seg_reg == SEG_POS_POS) begin
                        phase_next = PH_BLD_END;
                    end else begin
                        si       = seg_init(seg_reg + 1'b1, src_nn, src_np);
                        seg_next = seg_reg + 1'b1;
                        p_next   = si[2*CNT_W-1:CNT_W];
                        rem_next = si[CNT_W-1:0];
                    end
                end else begin
                    phase_next = PH_BLD_D;
                end
            end
            PH_BLD_D: begin
                neg_seg = (seg_reg <= SEG_NEG_NEG);
                if (seg_reg == SEG_SELF_NEG || seg_reg == SEG_SELF_POS) begin
                    d_w = 19'(sd_reg);
                end else begin
                    d_w = 19'($signed(dl_rd_data)) + 19'(sd_reg);
                end
                cond = neg_seg ? (d_w < 0) : (d_w > 0);
                if (cond && apply_reg[p_reg[FW-1:0]]) begin
                    if (wtot_reg >= CNT_W'(MAX_ENTRIES)) begin
                        ovf_next = 1'b1;
                    end else begin
                        wbuf_we    = 1'b1;
                        wbuf_wdata = {used_reg[p_reg[FW-1:0]], sat16(d_w)};
                        wtot_next  = wtot_reg + 1'b1;
                        wu_next    = wu_reg + CNT_W'(used_reg[p_reg[FW-1:0]]);
                        wn_next    = wn_reg + CNT_W'(neg_seg);
                    end
                end
                rem_next = rem_reg - 1'b1;
                if (seg_reg == SEG_POS_NEG || seg_reg == SEG_NEG_POS) begin
                    p_next = p_reg - 1'b1;
                end else begin
                    p_next = p_reg + 1'b1;
                end
                phase_next = PH_BLD_A;
            end
            PH_BLD_END: begin
                if (ovf_reg) begin
                    do_fail = 1'b1;
                    fail_st = ST_TOO_MANY;
                end else begin
                    do_fin = 1'b1;
                end
            end
            default: begin
                seg_next = seg_next;
            end
        endcase

        // hand the finished set or failure to the back
        if (do_fail) begin
            push_next        = 1'b1;
            job_next         = '0;
            job_next.status  = fail_st;
            phase_next       = PH_IDLE;
        end else if (do_fin) begin
            push_next         = 1'b1;
            job_next.is_set   = 1'b1;
            job_next.status   = ST_OK;
            job_next.num_neg  = wn_next;
            job_next.num_pos  = wtot_next - wn_next;
            job_next.num_used = wu_next;
            job_next.slot     = 7'(cur_next);
            phase_next        = PH_IDLE;
        end
    end

    // outputs
    always_comb begin
        s_ready = !back_stat.busy && !push_reg &&
                  (phase_reg != PH_BLD_A) && (phase_reg != PH_BLD_D) &&
                  (phase_reg != PH_BLD_END);
        cnt_rd_slot = src_reg;
        dl_rd_addr  = AW'(src_reg) * AW'(MAX_ENTRIES) + AW'(p_reg);
        buf_rd_data = wbuf_reg[buf_rd_idx];
        job_push    = push_reg;
        job         = job_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            zc_reg      <= '0;
            acc_reg     <= '0;
            used_reg    <= '0;
            apply_reg   <= '0;
            sd_reg      <= '0;
            run_reg     <= '0;
            ic_reg      <= '0;
            cur_reg     <= '0;
            src_reg     <= '0;
            slice_reg   <= 1'b0;
            cneg_reg    <= '0;
            cpos_reg    <= '0;
            maxrefs_reg <= MAX_REFS_RST;
            wtot_reg    <= '0;
            wn_reg      <= '0;
            wu_reg      <= '0;
            ovf_reg     <= 1'b0;
            seg_reg     <= '0;
            p_reg       <= '0;
            rem_reg     <= '0;
            push_reg    <= 1'b0;
            job_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            zc_reg      <= zc_next;
            acc_reg     <= acc_next;
            used_reg    <= used_next;
            apply_reg   <= apply_next;
            sd_reg      <= sd_next;
            run_reg     <= run_next;
            ic_reg      <= ic_next;
            cur_reg     <= cur_next;
            src_reg     <= src_next;
            slice_reg   <= slice_next;
            cneg_reg    <= cneg_next;
            cpos_reg    <= cpos_next;
            if (cfg_wr_en) begin
                maxrefs_reg <= cfg_wr_data;
            end
            wtot_reg    <= wtot_next;
            wn_reg      <= wn_next;
            wu_reg      <= wu_next;
            ovf_reg     <= ovf_next;
            seg_reg     <= seg_next;
            p_reg       <= p_next;
            rem_reg     <= rem_next;
            push_reg    <= push_next;
            job_reg     <= job_next;
        end
    end

    // work buffer: append at the fill pointer
    always_ff @(posedge aclk) begin
        if (wbuf_we) begin
            wbuf_reg[wtot_reg[EIW-1:0]] <= wbuf_wdata;
        end
    end

`include "hevc_short_term_rps_parser_macros.svh"

    `HSRP_ASSERT_NOW(a_push_idle, push_reg, phase_reg == PH_IDLE, "push without idle")
    `HSRP_ASSERT_NOW(a_bld_order, phase_reg == PH_BLD_D, $past(phase_reg) == PH_BLD_A, "bad walk step")
    `HSRP_ASSERT_NOW(a_fill_cap, 1'b1, int'(wtot_reg) <= MAX_ENTRIES, "work buffer overfilled")

endmodule

/* rtl/core/hsrp_back.sv */
// ----------------------------------------------------------------------------
// hsrp_back
// Stores a finished set in the tables and emits one result per entry (one status result for a failure or empty set).
// ----------------------------------------------------------------------------
module hsrp_back
    import hsrp_pkg::*;
#(
    parameter int MAX_SETS    = MAX_SETS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int SW  = $clog2(MAX_SETS + 1),
    localparam int AW  = $clog2((MAX_SETS + 1) * MAX_ENTRIES),
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_push,
    input  job_t               job,
    output back_stat_t         back_stat,
    input  logic [SW-1:0]      cnt_rd_slot,
    output logic               cnt_wr_en,
    output logic [SW-1:0]      cnt_wr_addr,
    output logic [2*CNT_W-1:0] cnt_wr_data,
    output logic               dl_wr_en,
    output logic [AW-1:0]      dl_wr_addr,
    output logic [DELTA_W-1:0] dl_wr_data,
    output logic [EIW-1:0]     buf_rd_idx,
    input  logic [DELTA_W:0]   buf_rd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rps_out_t           m_data
);

    back_state_t       state_reg, state_next;
    job_t              job_reg, job_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [MAX_SETS:0] cnt_valid_reg;
    logic              hit_reg;
    rps_out_t          out_reg, out_next;
    logic              mvalid_reg, mvalid_next;
    logic              load;
    logic [CNT_W-1:0]  total;
    logic              list_pos;

    assign load     = !mvalid_reg || m_ready;
    assign total    = job_reg.num_neg + job_reg.num_pos;
    assign list_pos = (k_reg >= job_reg.num_neg);

    // next state
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        case (state_reg)
            BK_IDLE: begin
                if (job_push) begin
                    job_next   = job;
                    k_next     = '0;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (load) begin
                    if (!job_reg.is_set || total == '0 || k_reg + 1'b1 == total) begin
                        state_next = BK_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs: result register and table writes
    always_comb begin
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        cnt_wr_en   = 1'b0;
        dl_wr_en    = 1'b0;
        if (load) begin
            mvalid_next = (state_reg == BK_EMIT);
        end
        if (state_reg == BK_EMIT && load) begin
            out_next = '0;
            if (!job_reg.is_set || total == '0) begin
                out_next.status = job_reg.status;
                out_next.last   = 1'b1;
                cnt_wr_en       = job_reg.is_set;
            end else begin
                out_next.entry_valid    = 1'b1;
                out_next.list_sel       = list_pos;
                out_next.entry_index    = 4'(list_pos ? k_reg - job_reg.num_neg : k_reg);
                out_next.delta_poc      = buf_rd_data[DELTA_W-1:0];
                out_next.used_by_curr   = buf_rd_data[DELTA_W];
                out_next.num_negative   = job_reg.num_neg;
                out_next.num_positive   = job_reg.num_pos;
                out_next.num_total_curr = job_reg.num_used;
                out_next.last           = (k_reg + 1'b1 == total);
                dl_wr_en                = 1'b1;
                cnt_wr_en               = (k_reg == '0);
            end
        end
        cnt_wr_addr       = SW'(job_reg.slot);
        cnt_wr_data       = {job_reg.num_neg, job_reg.num_pos};
        dl_wr_addr        = AW'(job_reg.slot) * AW'(MAX_ENTRIES) + AW'(k_reg);
        dl_wr_data        = buf_rd_data[DELTA_W-1:0];
        buf_rd_idx        = k_reg[EIW-1:0];
        m_valid           = mvalid_reg;
        m_data            = out_reg;
        back_stat.busy    = (state_reg == BK_EMIT);
        back_stat.cnt_hit = hit_reg;
    end

    // control registers and count valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            k_reg         <= '0;
            mvalid_reg    <= 1'b0;
            cnt_valid_reg <= '0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            mvalid_reg <= mvalid_next;
            if (cnt_wr_en) begin
                cnt_valid_reg[cnt_wr_addr] <= 1'b1;
            end
            hit_reg <= cnt_valid_reg[cnt_rd_slot];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

`include "hevc_short_term_rps_parser_macros.svh"

    `HSRP_ASSERT_NOW(a_k_range, state_reg == BK_EMIT && job_reg.is_set && total != '0, k_reg < total, "entry index past set")
    `HSRP_ASSERT_NOW(a_wr_emit, dl_wr_en, state_reg == BK_EMIT && job_reg.is_set, "table write outside a set")
    `HSRP_ASSERT_NEXT(a_last_idle, state_reg == BK_EMIT && load && out_next.last, state_reg == BK_IDLE, "no idle after last")

endmodule

/* rtl/core/hevc_short_term_rps_parser.sv */
// ----------------------------------------------------------------------------
// hevc_short_term_rps_parser
// Short-term reference picture set parser fed one header bit per item.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    rps_in_t (first, set_index, ...)
//   m_        out        m_valid / m_ready    rps_out_t (one entry per item)
//   cfg_      in         cfg_wr_en            max_refs (5 bits)
//
// Ending a predicted set walks the source set in six segments, visiting each
// stored entry in PH_BLD_A and PH_BLD_D (registered delta table read) and
// stepping to the next segment in PH_BLD_A. Results leave at one per cycle
// while m_ready is high; s_ready stays low while a set is written back and
// emitted. Reset is synchronous; the count table uses valid bits, so there
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module hevc_short_term_rps_parser
    import hsrp_pkg::*;
#(
    parameter int MAX_SETS    = MAX_SETS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rps_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rps_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    localparam int SW  = $clog2(MAX_SETS + 1);
    localparam int AW  = $clog2((MAX_SETS + 1) * MAX_ENTRIES);
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    back_stat_t         back_stat;
    logic [SW-1:0]      cnt_rd_slot;
    logic [2*CNT_W-1:0] cnt_rd_data;
    logic               cnt_wr_en;
    logic [SW-1:0]      cnt_wr_addr;
    logic [2*CNT_W-1:0] cnt_wr_data;
    logic [AW-1:0]      dl_rd_addr;
    logic [DELTA_W-1:0] dl_rd_data;
    logic               dl_wr_en;
    logic [AW-1:0]      dl_wr_addr;
    logic [DELTA_W-1:0] dl_wr_data;
    logic [EIW-1:0]     buf_rd_idx;
    logic [DELTA_W:0]   buf_rd_data;
    logic               job_push;
    job_t               job;

    // bit parser and set builder
    hsrp_front #(
        .MAX_SETS   (MAX_SETS),
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .back_stat  (back_stat),
        .cnt_rd_slot(cnt_rd_slot),
        .cnt_rd_data(cnt_rd_data),
        .dl_rd_addr (dl_rd_addr),
        .dl_rd_data (dl_rd_data),
        .buf_rd_idx (buf_rd_idx),
        .buf_rd_data(buf_rd_data),
        .job_push   (job_push),
        .job        (job)
    );

    // store and emit
    hsrp_back #(
        .MAX_SETS   (MAX_SETS),
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_push   (job_push),
        .job        (job),
        .back_stat  (back_stat),
        .cnt_rd_slot(cnt_rd_slot),
        .cnt_wr_en  (cnt_wr_en),
        .cnt_wr_addr(cnt_wr_addr),
        .cnt_wr_data(cnt_wr_data),
        .dl_wr_en   (dl_wr_en),
        .dl_wr_addr (dl_wr_addr),
        .dl_wr_data (dl_wr_data),
        .buf_rd_idx (buf_rd_idx),
        .buf_rd_data(buf_rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // per-slot negative and positive counts
    hsrp_ram #(
        .WIDTH(2 * CNT_W),
        .DEPTH(MAX_SETS + 1)
    ) u_cnt_ram (
        .aclk   (aclk),
        .wr_en  (cnt_wr_en),
        .wr_addr(cnt_wr_addr),
        .wr_data(cnt_wr_data),
        .rd_addr(cnt_rd_slot),
        .rd_data(cnt_rd_data)
    );

    // per-entry stored deltas
    hsrp_ram #(
        .WIDTH(DELTA_W),
        .DEPTH((MAX_SETS + 1) * MAX_ENTRIES)
    ) u_delta_ram (
        .aclk   (aclk),
        .wr_en  (dl_wr_en),
        .wr_addr(dl_wr_addr),
        .wr_data(dl_wr_data),
        .rd_addr(dl_rd_addr),
        .rd_data(dl_rd_data)
    );

endmodule
